[sv/utbd_pkg.sv]
// Shared constants, types and the digit character table for the base-digit converter.
package utbd_pkg;

	localparam int VALUE_BITS_DEF = 16;
	localparam int IN_BITS        = 16;
	localparam int RADIX_BITS     = 5;
	localparam int CHAR_BITS      = 7;
	localparam int DIG_BITS       = 4;
	localparam int MAX_DIGITS     = 16;
	localparam int CNT_BITS       = 5;
	localparam int STEP_BITS      = 8;

	localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
	localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(16);
	localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);

	localparam logic [CHAR_BITS-1:0] DIGIT_CHARS [16] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} utbd_state_t;

	typedef struct packed {
		logic load;
		logic div;
		logic emit;
	} utbd_cmd_t;

	typedef struct packed {
		logic div_last;
		logic quot_zero;
		logic stack_full;
		logic emit_last;
	} utbd_status_t;

endpackage

[sv/unsigned_to_base_digits.sv]
// Top level of the unsigned value to ASCII base-digit converter.
//
// Pulse start while busy is low to transfer one value; the block then
// divides it repeatedly by the configured radix (2 to 16, written through
// the cfg channel, reset 10, out-of-range writes saturate) and emits the
// digits as ASCII characters, most significant first, one per cycle, each
// marked by a single-cycle digit_valid. The receiver cannot stall: every
// digit must be taken in the cycle it appears. The final digit carries
// last_digit, and a value of zero gives the single digit '0'. The value is
// divided by the radix once per digit into a digit stack of up to sixteen
// digits, which is then emitted; the shared divider retires eight quotient
// bits per cycle on min(VALUE_BITS,16) input bits padded to whole bytes.
// The last digit appears in the first cycle with busy low, and a new start
// may be given in that same cycle. Write the radix only while idle.
module unsigned_to_base_digits
	import utbd_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [IN_BITS-1:0]    value,
	output logic                  digit_valid,
	output logic [CHAR_BITS-1:0]  digit_char,
	output logic                  last_digit,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [RADIX_BITS-1:0] cfg_data
);

	utbd_cmd_t    cmd;
	utbd_status_t status;

	// The radix register accepts a write in any cycle.
	assign cfg_ready = 1'b1;

	utbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	utbd_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.value       (value),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.digit_valid (digit_valid),
		.digit_char  (digit_char),
		.last_digit  (last_digit)
	);

	// Every strobed character is one of '0'-'9' or 'A'-'F'.
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> ((digit_char >= 7'h30 && digit_char <= 7'h39) ||
			(digit_char >= 7'h41 && digit_char <= 7'h46)))
		else $error("digit character outside the digit set");

	// An accepted start makes the block busy in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("start transfer did not raise busy");

	// Busy drops exactly as the last digit of a number is shown.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (digit_valid && last_digit))
		else $error("busy dropped without a final digit");

	// No digit follows the final one of a number directly.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(digit_valid && last_digit) |=> !digit_valid)
		else $error("digit strobed right after a final digit");

endmodule

[sv/utbd_ctrl.sv]
// Sequencing state machine of the base-digit converter.
module utbd_ctrl
	import utbd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  utbd_status_t status,
	output utbd_cmd_t    cmd,
	output logic         busy
);

	utbd_state_t state_q;
	utbd_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_last && (status.quot_zero || status.stack_full)) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.emit_last) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
				busy     = 1'b0;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

[sv/utbd_dp.sv]
// Datapath: radix register, chunked restoring divider, digit stack and result register.
module utbd_dp
	import utbd_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  utbd_cmd_t             cmd,
	output utbd_status_t          status,
	input  logic [IN_BITS-1:0]    value,
	input  logic                  cfg_wr,
	input  logic [RADIX_BITS-1:0] cfg_data,
	output logic                  digit_valid,
	output logic [CHAR_BITS-1:0]  digit_char,
	output logic                  last_digit
);

	// Bits of the input that take part, padded up to whole division chunks.
	localparam int VW = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
	localparam int DIV_CYCLES = (VW + STEP_BITS - 1) / STEP_BITS;
	localparam int DW = DIV_CYCLES * STEP_BITS;
	localparam int SW = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	logic [RADIX_BITS-1:0] radix_q;
	logic [DW-1:0]         work_q;
	logic [DIG_BITS-1:0]   rem_q;
	logic [SW-1:0]         stp_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [DIG_BITS-1:0]   stk_q [MAX_DIGITS];
	logic                  digit_valid_q;
	logic [CHAR_BITS-1:0]  digit_char_q;
	logic                  last_q;

	logic [DW-1:0]         work_nx;
	logic [DIG_BITS-1:0]   rem_nx;
	logic [CNT_BITS-1:0]   cnt_dec;
	logic [DIG_BITS-1:0]   rd_idx;
	logic                  div_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_wr) begin
			if (cfg_data < RADIX_MIN) begin
				radix_q <= RADIX_MIN;
			end else if (cfg_data > RADIX_MAX) begin
				radix_q <= RADIX_MAX;
			end else begin
				radix_q <= cfg_data;
			end
		end
	end

	// Eight restoring steps per cycle; the remainder stays below the radix.
	always_comb begin
		logic [RADIX_BITS-1:0] r;
		logic [DW-1:0]         w;
		r = {1'b0, rem_q};
		w = work_q;
		for (int i = 0; i < STEP_BITS; i++) begin
			r = {r[DIG_BITS-1:0], w[DW-1]};
			w = {w[DW-2:0], 1'b0};
			if (r >= radix_q) begin
				r    = r - radix_q;
				w[0] = 1'b1;
			end
		end
		rem_nx  = r[DIG_BITS-1:0];
		work_nx = w;
	end

	assign div_last = (stp_q == SW'(DIV_CYCLES - 1));
	assign cnt_dec  = cnt_q - CNT_BITS'(1);
	assign rd_idx   = cnt_dec[DIG_BITS-1:0];

	assign status.div_last   = div_last;
	assign status.quot_zero  = (work_nx == '0);
	assign status.stack_full = (cnt_q == CNT_BITS'(MAX_DIGITS - 1));
	assign status.emit_last  = (cnt_q == CNT_BITS'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= DW'(value[VW-1:0]);
			rem_q  <= '0;
		end else if (cmd.div) begin
			work_q <= work_nx;
			rem_q  <= div_last ? '0 : rem_nx;
			if (div_last) begin
				stk_q[cnt_q[DIG_BITS-1:0]] <= rem_nx;
			end
		end
		if (cmd.emit) begin
			digit_char_q <= DIGIT_CHARS[stk_q[rd_idx]];
			last_q       <= (cnt_q == CNT_BITS'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stp_q         <= '0;
			cnt_q         <= '0;
			digit_valid_q <= 1'b0;
		end else begin
			digit_valid_q <= cmd.emit;
			if (cmd.load) begin
				stp_q <= '0;
				cnt_q <= '0;
			end else if (cmd.div) begin
				if (div_last) begin
					stp_q <= '0;
					cnt_q <= cnt_q + CNT_BITS'(1);
				end else begin
					stp_q <= stp_q + SW'(1);
				end
			end else if (cmd.emit) begin
				cnt_q <= cnt_dec;
			end
		end
	end

	assign digit_valid = digit_valid_q;
	assign digit_char  = digit_char_q;
	assign last_digit  = last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(MAX_DIGITS))
		else $error("digit stack count beyond capacity");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> cnt_q != '0)
		else $error("emitting from an empty digit stack");

	a_radix_range: assert property (@(posedge clk) disable iff (!arst_n)
		radix_q >= RADIX_MIN && radix_q <= RADIX_MAX)
		else $error("radix register outside two to sixteen");

endmodule
